FILE: hdl/kmee_pkg.sv
package kmee_pkg;

   // Matrix geometry and event queue size
   localparam int NUM_COLS    = 5;
   localparam int NUM_ROWS    = 7;
   localparam int NUM_KEYS    = NUM_COLS * NUM_ROWS;
   localparam int KEY_IDX_W   = $clog2(NUM_KEYS);
   localparam int ROW_W       = $clog2(NUM_ROWS);
   localparam int COL_W       = $clog2(NUM_COLS);
   localparam int QUEUE_DEPTH = 16;

   // Bit positions of modifier and hotkey keys (col*NUM_ROWS+row)
   localparam int BIT_SYMBOL = 2;
   localparam int BIT_ALT    = 4;
   localparam int BIT_LSHIFT = 13;
   localparam int BIT_RSHIFT = 17;
   localparam int BIT_KEY_B  = 25;
   localparam int BIT_KEY_L  = 29;

   // Byte constants
   localparam logic [7:0] HOTKEY_L_BYTE = 8'h0C;
   localparam logic [7:0] CASE_OFFSET   = 8'd32;
   localparam logic [7:0] LOWER_A       = 8'h61;
   localparam logic [7:0] LOWER_Z       = 8'h7A;

   typedef struct packed {
      logic        operation;
      logic [34:0] key_state;
   } req_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       backlight_on;
      logic [4:0] pending_count;
      logic       dropped;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_READ,
      CMD_TOGGLE,
      CMD_HOTKEY_L,
      CMD_WALK
   } cmd_kind_type;

   // Classified transaction handed from front to back
   typedef struct packed {
      cmd_kind_type          kind;
      logic [NUM_KEYS-1:0]   fresh;
      logic                  sym;
      logic                  shift;
   } cmd_type;

   function automatic logic [7:0] normal_key(input logic [KEY_IDX_W-1:0] k);
      logic [7:0] b;
      unique case (k)
         6'd0:  b = "q";   6'd1:  b = "w";   6'd2:  b = 8'h00; 6'd3:  b = "a";
         6'd4:  b = 8'h00; 6'd5:  b = " ";   6'd6:  b = 8'h00; 6'd7:  b = "e";
         6'd8:  b = "s";   6'd9:  b = "d";   6'd10: b = "p";   6'd11: b = "x";
         6'd12: b = "z";   6'd13: b = 8'h00; 6'd14: b = "r";   6'd15: b = "g";
         6'd16: b = "t";   6'd17: b = 8'h00; 6'd18: b = "v";   6'd19: b = "c";
         6'd20: b = "f";   6'd21: b = "u";   6'd22: b = "h";   6'd23: b = "y";
         6'd24: b = 8'h0A; 6'd25: b = "b";   6'd26: b = "n";   6'd27: b = "j";
         6'd28: b = "o";   6'd29: b = "l";   6'd30: b = "i";   6'd31: b = 8'h08;
         6'd32: b = "$";   6'd33: b = "m";   6'd34: b = "k";
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   function automatic logic [7:0] symbol_key(input logic [KEY_IDX_W-1:0] k);
      logic [7:0] b;
      unique case (k)
         6'd0:  b = "#";   6'd1:  b = "1";   6'd2:  b = 8'h00; 6'd3:  b = "*";
         6'd4:  b = 8'h00; 6'd5:  b = " ";   6'd6:  b = "0";   6'd7:  b = "2";
         6'd8:  b = "4";   6'd9:  b = "5";   6'd10: b = "@";   6'd11: b = "8";
         6'd12: b = "7";   6'd13: b = 8'h00; 6'd14: b = "3";   6'd15: b = "/";
         6'd16: b = "(";   6'd17: b = 8'h00; 6'd18: b = "?";   6'd19: b = "9";
         6'd20: b = "6";   6'd21: b = "_";   6'd22: b = ":";   6'd23: b = ")";
         6'd24: b = 8'h0A; 6'd25: b = "!";   6'd26: b = ",";   6'd27: b = ";";
         6'd28: b = "+";   6'd29: b = 8'h22; 6'd30: b = "-";   6'd31: b = 8'h7F;
         6'd32: b = 8'h00; 6'd33: b = ".";   6'd34: b = 8'h27;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

FILE: hdl/kmee_front.sv
module kmee_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  kmee_pkg::req_type req_data,
   input  logic              cmdq_full,
   output logic              busy,
   output logic              cmd_push,
   output kmee_pkg::cmd_type cmd
);

   logic [kmee_pkg::NUM_KEYS-1:0] prev_keys_ff;
   logic [kmee_pkg::NUM_KEYS-1:0] prev_keys_in;
   logic [kmee_pkg::NUM_KEYS-1:0] now_keys;
   logic [kmee_pkg::NUM_KEYS-1:0] fresh;
   logic                          alt;

   assign busy     = cmdq_full;
   assign cmd_push = start && !cmdq_full;

   // Find new presses against the previous frame
   assign now_keys = req_data.key_state;
   assign fresh    = now_keys & ~prev_keys_ff;
   assign alt      = now_keys[kmee_pkg::BIT_ALT];

   // Classify the transaction
   always_comb begin
      cmd.fresh = fresh;
      cmd.sym   = now_keys[kmee_pkg::BIT_SYMBOL];
      cmd.shift = now_keys[kmee_pkg::BIT_LSHIFT] || now_keys[kmee_pkg::BIT_RSHIFT];
      if (req_data.operation) begin
         cmd.kind = kmee_pkg::CMD_READ;
      end else if (alt && fresh[kmee_pkg::BIT_KEY_B]) begin
         cmd.kind = kmee_pkg::CMD_TOGGLE;
      end else if (alt && fresh[kmee_pkg::BIT_KEY_L]) begin
         cmd.kind = kmee_pkg::CMD_HOTKEY_L;
      end else begin
         cmd.kind = kmee_pkg::CMD_WALK;
      end
   end

   // Track the last scanned frame; reads leave it alone
   assign prev_keys_in = (cmd_push && !req_data.operation) ? now_keys : prev_keys_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_keys_ff <= '0;
      end else begin
         prev_keys_ff <= prev_keys_in;
      end
   end

endmodule

FILE: hdl/kmee_cmd_fifo.sv
module kmee_cmd_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  kmee_pkg::cmd_type push_cmd,
   input  logic              pop,
   output logic              full,
   output logic              valid,
   output kmee_pkg::cmd_type pop_cmd
);

   kmee_pkg::cmd_type slot_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       do_push;
   logic       do_pop;

   assign full    = (count_ff == 2'd2);
   assign valid   = (count_ff != 2'd0);
   assign pop_cmd = slot_ff[rd_ptr_ff];

   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold queued transactions
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: hdl/kmee_back.sv
module kmee_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  kmee_pkg::cmd_type cmd,
   output logic              cmd_pop,
   output logic              rsp_valid,
   output kmee_pkg::rsp_type rsp_data
);

   localparam int QIDX_W = $clog2(kmee_pkg::QUEUE_DEPTH);
   localparam int FILL_W = $clog2(kmee_pkg::QUEUE_DEPTH + 1);
   localparam int SUM_W  = FILL_W + 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_WALK
   } state_type;

   state_type                     state_ff, state_in;
   logic                          backlight_ff, backlight_in;
   logic [QIDX_W-1:0]             head_ff, head_in;
   logic [FILL_W-1:0]             fill_ff, fill_in;
   logic [kmee_pkg::ROW_W-1:0]    row_ff, row_in;
   logic [kmee_pkg::COL_W-1:0]    col_ff, col_in;
   logic [kmee_pkg::NUM_KEYS-1:0] fresh_ff, fresh_in;
   logic                          sym_ff, sym_in;
   logic                          shift_ff, shift_in;
   logic                          drop_ff, drop_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   kmee_pkg::rsp_type             rsp_ff, rsp_in;

   logic [7:0]                    event_mem [kmee_pkg::QUEUE_DEPTH];
   logic [7:0]                    rd_data_ff;

   logic                          push_req;
   logic [7:0]                    push_byte;
   logic                          queue_full;
   logic                          wr_en;
   logic [SUM_W-1:0]              tail_sum;
   logic [QIDX_W-1:0]             tail;
   logic [QIDX_W-1:0]             head_next;

   logic [kmee_pkg::KEY_IDX_W-1:0] key_idx;
   logic [7:0]                     nb;
   logic [7:0]                     sb;
   logic                           key_hit;
   logic [7:0]                     key_byte;
   logic                           last_key;
   logic [FILL_W+4:0]              fill_wide;

   assign queue_full = (fill_ff >= FILL_W'(kmee_pkg::QUEUE_DEPTH));
   assign wr_en      = push_req && !queue_full;

   // Locate the tail slot, wrapping at the queue depth
   always_comb begin
      tail_sum = SUM_W'(head_ff) + SUM_W'(fill_ff);
      if (tail_sum >= SUM_W'(kmee_pkg::QUEUE_DEPTH)) begin
         tail_sum = tail_sum - SUM_W'(kmee_pkg::QUEUE_DEPTH);
      end
      tail = tail_sum[QIDX_W-1:0];
   end

   assign head_next = (head_ff == QIDX_W'(kmee_pkg::QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;

   // Look up the key under the walk counters
   assign key_idx  = kmee_pkg::KEY_IDX_W'(col_ff) * kmee_pkg::KEY_IDX_W'(kmee_pkg::NUM_ROWS)
                   + kmee_pkg::KEY_IDX_W'(row_ff);
   assign nb       = kmee_pkg::normal_key(key_idx);
   assign sb       = kmee_pkg::symbol_key(key_idx);
   assign key_hit  = fresh_ff[key_idx] && ((nb != 8'h00) || (sb != 8'h00));
   assign last_key = (row_ff == kmee_pkg::ROW_W'(kmee_pkg::NUM_ROWS - 1))
                  && (col_ff == kmee_pkg::COL_W'(kmee_pkg::NUM_COLS - 1));

   // Pick the byte from the symbol or the normal table
   always_comb begin
      if (sym_ff) begin
         key_byte = sb;
      end else if (shift_ff && (nb >= kmee_pkg::LOWER_A) && (nb <= kmee_pkg::LOWER_Z)) begin
         key_byte = nb - kmee_pkg::CASE_OFFSET;
      end else begin
         key_byte = nb;
      end
   end

   assign fill_wide = {5'b0, fill_in};

   // Sequence the transaction and form the result
   always_comb begin
      state_in     = state_ff;
      backlight_in = backlight_ff;
      head_in      = head_ff;
      fill_in      = fill_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      fresh_in     = fresh_ff;
      sym_in       = sym_ff;
      shift_in     = shift_ff;
      drop_in      = drop_ff;
      rsp_valid_in = 1'b0;
      push_req     = 1'b0;
      push_byte    = kmee_pkg::HOTKEY_L_BYTE;
      cmd_pop      = 1'b0;
      rsp_in       = rsp_ff;
      rsp_in.data_byte = 8'h00;
      rsp_in.dropped   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               unique case (cmd.kind)
                  kmee_pkg::CMD_READ: begin
                     state_in = ST_READ;
                  end
                  kmee_pkg::CMD_TOGGLE: begin
                     backlight_in = !backlight_ff;
                     rsp_valid_in = 1'b1;
                  end
                  kmee_pkg::CMD_HOTKEY_L: begin
                     push_req       = 1'b1;
                     rsp_in.dropped = queue_full;
                     rsp_valid_in   = 1'b1;
                  end
                  default: begin
                     fresh_in = cmd.fresh;
                     sym_in   = cmd.sym;
                     shift_in = cmd.shift;
                     row_in   = '0;
                     col_in   = '0;
                     drop_in  = 1'b0;
                     state_in = ST_WALK;
                  end
               endcase
            end
         end
         ST_READ: begin
            if (fill_ff != '0) begin
               rsp_in.data_byte = rd_data_ff;
               head_in          = head_next;
            end
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_WALK: begin
            push_req  = key_hit;
            push_byte = key_byte;
            drop_in   = drop_ff || (key_hit && queue_full);
            if (col_ff == kmee_pkg::COL_W'(kmee_pkg::NUM_COLS - 1)) begin
               col_in = '0;
               row_in = row_ff + 1'b1;
            end else begin
               col_in = col_ff + 1'b1;
            end
            if (last_key) begin
               rsp_in.dropped = drop_in;
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Occupancy follows the push or the pop of this cycle
      if (wr_en) begin
         fill_in = fill_ff + 1'b1;
      end else if ((state_ff == ST_READ) && (fill_ff != '0)) begin
         fill_in = fill_ff - 1'b1;
      end

      rsp_in.backlight_on  = backlight_in;
      rsp_in.pending_count = fill_wide[4:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         backlight_ff <= 1'b0;
         head_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         backlight_ff <= backlight_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      row_ff   <= row_in;
      col_ff   <= col_in;
      fresh_ff <= fresh_in;
      sym_ff   <= sym_in;
      shift_ff <= shift_in;
      drop_ff  <= drop_in;
      rsp_ff   <= rsp_in;
   end

   // Event byte storage with registered read at the head
   always_ff @(posedge clock) begin
      if (wr_en) begin
         event_mem[tail] <= push_byte;
      end
      rd_data_ff <= event_mem[head_ff];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: hdl/key_matrix_event_encoder_core.sv
// Each accepted request passes through the transaction queue to the back end, which
// registers its result; a scan frame first runs a 35-key walk, one key a cycle.
// The back end takes one transaction at a time and pops the next only when idle;
// a two-entry transaction queue lets the front accept while the walk runs.
// Results are strobed for one cycle and never stall. Synchronous active-high reset
// clears the previous frame, queue pointers and backlight; event storage is not cleared.
module key_matrix_event_encoder_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  kmee_pkg::req_type req_data,
   output logic              busy,
   output logic              rsp_valid,
   output kmee_pkg::rsp_type rsp_data
);

   logic              cmdq_full;
   logic              cmd_push;
   kmee_pkg::cmd_type push_cmd;
   logic              cmd_valid;
   logic              cmd_pop;
   kmee_pkg::cmd_type pop_cmd;

   kmee_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .cmdq_full (cmdq_full),
      .busy      (busy),
      .cmd_push  (cmd_push),
      .cmd       (push_cmd)
   );

   kmee_cmd_fifo u_cmd_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (push_cmd),
      .pop      (cmd_pop),
      .full     (cmdq_full),
      .valid    (cmd_valid),
      .pop_cmd  (pop_cmd)
   );

   kmee_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (pop_cmd),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: tb/sv/key_event_checker.sv
module key_event_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  kmee_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  kmee_pkg::rsp_type rsp_data,
   output int                mismatch_count,
   output int                waiting_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // Byte tables, index col*NUM_ROWS+row
   localparam logic [7:0] PLAIN_MAP [kmee_pkg::NUM_KEYS] = '{
      8'h71, 8'h77, 8'h00, 8'h61, 8'h00, 8'h20, 8'h00,
      8'h65, 8'h73, 8'h64, 8'h70, 8'h78, 8'h7A, 8'h00,
      8'h72, 8'h67, 8'h74, 8'h00, 8'h76, 8'h63, 8'h66,
      8'h75, 8'h68, 8'h79, 8'h0A, 8'h62, 8'h6E, 8'h6A,
      8'h6F, 8'h6C, 8'h69, 8'h08, 8'h24, 8'h6D, 8'h6B
   };
   localparam logic [7:0] SYMBOL_MAP [kmee_pkg::NUM_KEYS] = '{
      8'h23, 8'h31, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h30,
      8'h32, 8'h34, 8'h35, 8'h40, 8'h38, 8'h37, 8'h00,
      8'h33, 8'h2F, 8'h28, 8'h00, 8'h3F, 8'h39, 8'h36,
      8'h5F, 8'h3A, 8'h29, 8'h0A, 8'h21, 8'h2C, 8'h3B,
      8'h2B, 8'h22, 8'h2D, 8'h7F, 8'h00, 8'h2E, 8'h27
   };

   // Shadow state of the encoder
   logic [kmee_pkg::NUM_KEYS-1:0] last_frame;
   logic [7:0]                    event_bytes[$];
   logic                          light;
   kmee_pkg::rsp_type             expected_rsp[$];
   int                            fail_total = 0;

   // Push one event byte, or flag it lost when the queue is full
   function automatic void queue_event(input logic [7:0] b, inout logic lost);
      if (event_bytes.size() >= kmee_pkg::QUEUE_DEPTH) begin
         lost = 1'b1;
      end else begin
         event_bytes.push_back(b);
      end
   endfunction

   // Apply one transaction to the shadow state and return its result
   function automatic kmee_pkg::rsp_type encode_item(input kmee_pkg::req_type item);
      kmee_pkg::rsp_type             r;
      logic [kmee_pkg::NUM_KEYS-1:0] now;
      logic [kmee_pkg::NUM_KEYS-1:0] fresh;
      logic                          sym;
      logic                          shift;
      logic                          lost;
      logic [7:0]                    nb;
      logic [7:0]                    sb;
      logic [7:0]                    b;
      int                            row;
      int                            col;
      int                            k;
      r    = '0;
      lost = 1'b0;
      if (item.operation) begin
         if (event_bytes.size() > 0) begin
            r.data_byte = event_bytes.pop_front();
         end
      end else begin
         now        = item.key_state;
         fresh      = now & ~last_frame;
         last_frame = now;
         if (now[kmee_pkg::BIT_ALT] && fresh[kmee_pkg::BIT_KEY_B]) begin
            light = ~light;
         end else if (now[kmee_pkg::BIT_ALT] && fresh[kmee_pkg::BIT_KEY_L]) begin
            queue_event(kmee_pkg::HOTKEY_L_BYTE, lost);
         end else begin
            sym   = now[kmee_pkg::BIT_SYMBOL];
            shift = now[kmee_pkg::BIT_LSHIFT] | now[kmee_pkg::BIT_RSHIFT];
            // Walk rows outer, columns inner
            for (row = 0; row < kmee_pkg::NUM_ROWS; row++) begin
               for (col = 0; col < kmee_pkg::NUM_COLS; col++) begin
                  k  = col * kmee_pkg::NUM_ROWS + row;
                  nb = PLAIN_MAP[k];
                  sb = SYMBOL_MAP[k];
                  if (fresh[k] && (nb != 8'h00 || sb != 8'h00)) begin
                     if (sym) begin
                        b = sb;
                     end else if (shift && nb >= kmee_pkg::LOWER_A &&
                                  nb <= kmee_pkg::LOWER_Z) begin
                        b = nb - kmee_pkg::CASE_OFFSET;
                     end else begin
                        b = nb;
                     end
                     queue_event(b, lost);
                  end
               end
            end
         end
      end
      r.backlight_on  = light;
      r.pending_count = 5'(event_bytes.size());
      r.dropped       = lost;
      return r;
   endfunction

   // Predict on accept, then compare any result against the oldest expectation
   always @(posedge clock) begin : watch
      kmee_pkg::rsp_type want;
      if (reset) begin
         last_frame = '0;
         light      = 1'b0;
         event_bytes.delete();
         expected_rsp.delete();
      end else begin
         if (start && !busy) begin
            expected_rsp.push_back(encode_item(req_data));
         end
         if (rsp_valid) begin
            if (expected_rsp.size() == 0) begin
               fail_total++;
               if (fail_total <= 10) begin
                  $display("[%0t] unexpected result: data=%h light=%b count=%0d drop=%b",
                           $realtime, rsp_data.data_byte, rsp_data.backlight_on,
                           rsp_data.pending_count, rsp_data.dropped);
               end
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data.data_byte !== want.data_byte ||
                   rsp_data.backlight_on !== want.backlight_on ||
                   rsp_data.pending_count !== want.pending_count ||
                   rsp_data.dropped !== want.dropped) begin
                  fail_total++;
                  if (fail_total <= 10) begin
                     $display("[%0t] mismatch: expected data=%h light=%b count=%0d drop=%b",
                              $realtime, want.data_byte, want.backlight_on,
                              want.pending_count, want.dropped);
                     $display("             actual   data=%h light=%b count=%0d drop=%b",
                              rsp_data.data_byte, rsp_data.backlight_on,
                              rsp_data.pending_count, rsp_data.dropped);
                  end
               end
            end
         end
      end
      waiting_count  <= expected_rsp.size();
      mismatch_count <= fail_total;
   end

endmodule

FILE: tb/sv/key_matrix_event_encoder_core_test.sv
module key_matrix_event_encoder_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_TARGET = 1850;
   localparam int CYCLE_LIMIT = 900000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   kmee_pkg::req_type req_data = '0;
   logic              busy;
   logic              rsp_valid;
   kmee_pkg::rsp_type rsp_data;
   int                mismatch_count;
   int                waiting_count;

   int cycle_count = 0;
   int burst_left  = 0;
   int scan_total  = 0;
   int read_total  = 0;

   key_matrix_event_encoder_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   key_event_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .waiting_count  (waiting_count)
   );

   always #1 clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic logic [kmee_pkg::NUM_KEYS-1:0] key_bit(input int k);
      logic [kmee_pkg::NUM_KEYS-1:0] v;
      v    = '0;
      v[k] = 1'b1;
      return v;
   endfunction

   function automatic logic [kmee_pkg::NUM_KEYS-1:0] any_keys();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[kmee_pkg::NUM_KEYS-1:0];
   endfunction

   function automatic logic [kmee_pkg::NUM_KEYS-1:0] any_key();
      return key_bit($urandom_range(0, kmee_pkg::NUM_KEYS - 1));
   endfunction

   // Drive one transaction at the falling edge and hold it until accepted
   task automatic send_item(input logic op, input logic [kmee_pkg::NUM_KEYS-1:0] keys);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
         if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(1, 30);
      end
      start              = 1'b1;
      req_data.operation = op;
      req_data.key_state = keys;
      @(posedge clock);
      while (busy) @(posedge clock);
      burst_left--;
      if (op) read_total++;
      else scan_total++;
      @(negedge clock);
   endtask

   task automatic scan(input logic [kmee_pkg::NUM_KEYS-1:0] keys);
      send_item(1'b0, keys);
   endtask

   task automatic host_read();
      send_item(1'b1, any_keys());
   endtask

   // Interleave host reads at the given percentage
   task automatic some_reads(input int pct);
      while ($urandom_range(0, 99) < pct) host_read();
   endtask

   // Hold off until every outstanding result has come back
   task automatic settle();
      start      = 1'b0;
      burst_left = 0;
      @(negedge clock);
      while (waiting_count != 0) @(negedge clock);
   endtask

   function automatic logic [kmee_pkg::NUM_KEYS-1:0] pick_mods();
      case ($urandom_range(0, 5))
         0: return key_bit(kmee_pkg::BIT_LSHIFT);
         1: return key_bit(kmee_pkg::BIT_RSHIFT);
         2: return key_bit(kmee_pkg::BIT_SYMBOL);
         3: return key_bit(kmee_pkg::BIT_LSHIFT) | key_bit(kmee_pkg::BIT_SYMBOL);
         default: return '0;
      endcase
   endfunction

   initial begin : stimulus
      logic [kmee_pkg::NUM_KEYS-1:0] mods;
      logic [kmee_pkg::NUM_KEYS-1:0] held;
      logic [kmee_pkg::NUM_KEYS-1:0] hot;
      int                            pct;
      int                            kind;

      repeat (6) @(negedge clock);
      reset = 1'b0;

      // Directed: empty read, plain, shifted and symbol keys, empty table entries
      host_read();
      scan('0);
      scan(key_bit(0));
      scan(key_bit(kmee_pkg::BIT_LSHIFT) | key_bit(3));
      scan('0);
      scan(key_bit(kmee_pkg::BIT_RSHIFT) | key_bit(5) | key_bit(32));
      scan('0);
      scan(key_bit(kmee_pkg::BIT_SYMBOL) | key_bit(6) | key_bit(32) | key_bit(31));
      scan('0);
      // Hotkeys: toggle, held B is not a new press, Alt+L, both at once
      scan(key_bit(kmee_pkg::BIT_ALT) | key_bit(kmee_pkg::BIT_KEY_B));
      scan(key_bit(kmee_pkg::BIT_ALT) | key_bit(kmee_pkg::BIT_KEY_B) | key_bit(1));
      scan('0);
      scan(key_bit(kmee_pkg::BIT_ALT) | key_bit(kmee_pkg::BIT_KEY_L) | key_bit(0));
      scan('0);
      scan(key_bit(kmee_pkg::BIT_ALT) | key_bit(kmee_pkg::BIT_KEY_B)
           | key_bit(kmee_pkg::BIT_KEY_L));
      scan('0);
      // Overflow the queue, then a dropped Alt+L and reads on a full queue
      scan(~key_bit(kmee_pkg::BIT_ALT));
      scan('0);
      scan(key_bit(kmee_pkg::BIT_ALT) | key_bit(kmee_pkg::BIT_KEY_L));
      host_read();
      send_item(1'b1, '1);
      send_item(1'b1, '0);
      scan(~key_bit(kmee_pkg::BIT_ALT));
      settle();

      // Random: mostly well-formed key sequences, some noise
      while (scan_total + read_total < ITEM_TARGET) begin
         case ($urandom_range(0, 3))
            0: pct = 10;
            1: pct = 35;
            2: pct = 55;
            default: pct = 85;
         endcase
         kind = $urandom_range(0, 99);
         if (kind < 40) begin
            // Typing: press and release keys under a held modifier
            mods = pick_mods();
            repeat ($urandom_range(2, 8)) begin
               scan(mods | any_key() | (($urandom_range(0, 2) == 0) ? any_key() : '0));
               some_reads(pct);
               scan(mods);
               some_reads(pct);
            end
            scan('0);
         end else if (kind < 55) begin
            // Hotkey: Alt down, then B or L (sometimes already held)
            held = key_bit(kmee_pkg::BIT_ALT);
            if ($urandom_range(0, 3) == 0) held |= key_bit(kmee_pkg::BIT_KEY_B);
            if ($urandom_range(0, 3) == 0) held |= any_key();
            scan(held);
            case ($urandom_range(0, 2))
               0: hot = key_bit(kmee_pkg::BIT_KEY_B);
               1: hot = key_bit(kmee_pkg::BIT_KEY_L);
               default: hot = key_bit(kmee_pkg::BIT_KEY_B) | key_bit(kmee_pkg::BIT_KEY_L);
            endcase
            scan(held | hot | (($urandom_range(0, 1) == 0) ? any_key() : '0));
            some_reads(pct);
            scan('0);
         end else if (kind < 65) begin
            // Rollover: keep adding keys while others stay down
            held = pick_mods();
            repeat ($urandom_range(2, 6)) begin
               held |= any_key();
               scan(held);
               some_reads(pct);
            end
            scan('0);
         end else if (kind < 77) begin
            // Noise: arbitrary frames
            repeat ($urandom_range(1, 4)) begin
               scan(any_keys());
               some_reads(pct);
            end
         end else begin
            // Drain the queue, often past empty
            repeat ($urandom_range(1, 20)) host_read();
         end
         if ($urandom_range(0, 19) == 0) settle();
      end

      // Wait out the tail and give the verdict
      settle();
      repeat (60) @(negedge clock);
      $display("Covered %0d scan frames and %0d host reads: hotkeys, shift, symbol,",
               scan_total, read_total);
      $display("queue overflow and reads of an empty queue, under random idle gaps.");
      if (mismatch_count == 0 && waiting_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
